// ===== hdl/psdc_pkg.sv =====
`default_nettype none

package psdc_pkg;

    localparam int MAC_W      = 48;
    localparam int LEN_W      = 6;
    localparam int SSID_BYTES = 32;
    localparam int SSID_W     = 8 * SSID_BYTES;
    localparam int SLOT_W     = 4;
    // wide enough for any supported table depth (up to 64 slots)
    localparam int SLOT_IDX_W = 6;

    localparam int S_TDATA_W  = 312;
    localparam int M_TDATA_W  = 8;

    typedef enum logic [1:0] {
        OUT_REPEAT = 2'd0,
        OUT_UPDATE = 2'd1,
        OUT_INSERT = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    // lookup key broadcast to every cell
    typedef struct packed {
        logic [SSID_W-1:0]     ssid;
        logic [SSID_BYTES-1:0] byte_en;
        logic [LEN_W-1:0]      len;
        logic [MAC_W-1:0]      src;
    } query_t;

    // scan token handed from cell to cell
    typedef struct packed {
        logic                  act;
        logic                  hit;
        logic                  same;
        logic [SLOT_IDX_W-1:0] idx;
    } tok_t;

    // write-back command broadcast to every cell
    typedef struct packed {
        logic                  en;
        logic                  insert;
        logic [SLOT_IDX_W-1:0] idx;
    } wr_t;

endpackage

`default_nettype wire

// ===== hdl/psdc_cell.sv =====
`default_nettype none

module psdc_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  psdc_pkg::query_t query,
    input  psdc_pkg::tok_t   tok_in,
    output psdc_pkg::tok_t   tok_out,
    input  psdc_pkg::wr_t    wr
);
    import psdc_pkg::*;

    logic              valid_reg;
    logic [MAC_W-1:0]  src_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [SSID_W-1:0] ssid_reg;
    tok_t              tok_reg;
    tok_t              tok_next;

    logic src_match;
    logic ssid_same;
    logic wr_here;

    assign src_match = valid_reg && (src_reg == query.src);
    assign wr_here   = wr.en && (wr.idx == SLOT_IDX_W'(CELL_IDX));

    // only bytes below the length take part
    always_comb begin
        ssid_same = (len_reg == query.len);
        for (int b = 0; b < SSID_BYTES; b++) begin
            if (query.byte_en[b] && (ssid_reg[8*b +: 8] != query.ssid[8*b +: 8])) begin
                ssid_same = 1'b0;
            end
        end
    end

    // first valid source hit claims the token
    always_comb begin
        tok_next = tok_in;
        if (tok_in.act && !tok_in.hit && src_match) begin
            tok_next.hit  = 1'b1;
            tok_next.same = ssid_same;
            tok_next.idx  = SLOT_IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            tok_reg <= tok_next;
            if (wr_here && wr.insert) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_here) begin
            len_reg  <= query.len;
            ssid_reg <= query.ssid;
            if (wr.insert) begin
                src_reg <= query.src;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== hdl/probe_source_ssid_dedup_cache_top.sv =====
`default_nettype none

// an item is handled in order: accept, then the scan token walks the row of
//   ENTRIES cells one cell per cycle, then the result is captured and, once the
//   output is free, written back and registered; one item is scanned at a time
// reset: synchronous active-low aresetn clears all valid bits, the
//   replacement pointer and the handshake state; no clearing pass is needed
// a new item may be accepted while the previous result still waits on m_tready
module probe_source_ssid_dedup_cache_top #(
    parameter int ENTRIES = 16
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    // source_mac[47:0], name_len[53:48], ssid_word0[117:54], ssid_word1[181:118],
    // ssid_word2[245:182], ssid_word3[309:246], zero pad[311:310]
    input  wire  [psdc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // is_new[0], outcome[2:1], slot[6:3], zero pad[7]
    output logic [psdc_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tvalid,
    input  wire                             m_tready
);
    import psdc_pkg::*;

    localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    state_t            state_reg, state_next;
    query_t            q_reg, q_next;
    logic              inj_reg;
    tok_t              res_reg;
    logic [IDXW-1:0]   ptr_reg, ptr_next;
    logic              m_valid_reg, m_valid_next;
    logic              is_new_reg, is_new_next;
    outcome_t          outcome_reg, outcome_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    tok_t              tok [0:ENTRIES];
    wr_t               wr;
    logic              s_acc;
    logic              out_free;
    logic [LEN_W-1:0]  in_len;
    logic [LEN_W-1:0]  sat_len;

    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // unpack input item, saturate length to 32 bytes
    assign in_len  = s_tdata[53:48];
    assign sat_len = (in_len > LEN_W'(SSID_BYTES)) ? LEN_W'(SSID_BYTES) : in_len;

    always_comb begin
        q_next.src  = s_tdata[47:0];
        q_next.len  = sat_len;
        q_next.ssid = s_tdata[309:54];
        for (int b = 0; b < SSID_BYTES; b++) begin
            q_next.byte_en[b] = (LEN_W'(b) < sat_len);
        end
    end

    // token enters the first cell the cycle after accept
    always_comb begin
        tok[0]      = '0;
        tok[0].act  = inj_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            psdc_cell #(
                .CELL_IDX(gi)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .query   (q_reg),
                .tok_in  (tok[gi]),
                .tok_out (tok[gi+1]),
                .wr      (wr)
            );
        end
    endgenerate

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_SCAN;
            ST_SCAN:  if (tok[ENTRIES].act) state_next = ST_WRITE;
            ST_WRITE: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs and write-back
    always_comb begin
        s_tready     = 1'b0;
        wr           = '0;
        ptr_next     = ptr_reg;
        m_valid_next = m_valid_reg && !m_tready;
        is_new_next  = is_new_reg;
        outcome_next = outcome_reg;
        slot_next    = slot_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_SCAN: begin
            end
            ST_WRITE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (res_reg.hit && res_reg.same) begin
                        // repeat: nothing to store
                        is_new_next  = 1'b0;
                        outcome_next = OUT_REPEAT;
                        slot_next    = SLOT_W'(res_reg.idx);
                    end else if (res_reg.hit) begin
                        // same source, different ssid: refresh in place
                        wr.en        = 1'b1;
                        wr.idx       = res_reg.idx;
                        is_new_next  = 1'b1;
                        outcome_next = OUT_UPDATE;
                        slot_next    = SLOT_W'(res_reg.idx);
                    end else begin
                        // unknown source: fifo replacement
                        wr.en        = 1'b1;
                        wr.insert    = 1'b1;
                        wr.idx       = SLOT_IDX_W'(ptr_reg);
                        is_new_next  = 1'b1;
                        outcome_next = OUT_INSERT;
                        slot_next    = SLOT_W'(ptr_reg);
                        ptr_next     = (ptr_reg == IDXW'(ENTRIES - 1)) ? '0
                                                                       : ptr_reg + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            inj_reg     <= 1'b0;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            inj_reg     <= s_acc;
            ptr_reg     <= ptr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            q_reg <= q_next;
        end
        if (state_reg == ST_SCAN && tok[ENTRIES].act) begin
            res_reg <= tok[ENTRIES];
        end
        is_new_reg  <= is_new_next;
        outcome_reg <= outcome_next;
        slot_reg    <= slot_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, slot_reg, outcome_reg, is_new_reg};

endmodule

`default_nettype wire

// ===== hdl/psdc_checker.sv =====
`default_nettype none

module psdc_checker (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire [psdc_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire                            m_tvalid,
    input wire                            m_tready
);
    import psdc_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight: busy right after accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a second item while scanning");

    // is_new agrees with outcome
    a_is_new: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] != OUT_REPEAT)))
        else $error("is_new disagrees with outcome");

    // no result without a scan before it
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared without a scan");

endmodule

bind probe_source_ssid_dedup_cache_top psdc_checker u_psdc_checker (.*);

`default_nettype wire

// ===== dv/probe_source_ssid_dedup_cache_top_tb.sv =====
// expected-verdict tracker: keeps its own copy of the source table and
// predicts the verdict for every probe the block accepts
class probe_dedup_scoreboard;

    typedef struct packed {
        logic                        is_new;
        psdc_pkg::outcome_t          outcome;
        logic [psdc_pkg::SLOT_W-1:0] slot;
    } verdict_t;

    int depth;
    bit                           slot_valid [64];
    bit [psdc_pkg::MAC_W-1:0]     slot_source[64];
    bit [psdc_pkg::LEN_W-1:0]     slot_length[64];
    bit [psdc_pkg::SSID_W-1:0]    slot_ssid  [64];
    int                           rotor;
    verdict_t                     verdicts_due[$];
    int n_mismatch;
    int n_probes;
    int n_repeat;
    int n_update;
    int n_insert;

    function new(int entries);
        depth      = entries;
        rotor      = 0;
        n_mismatch = 0;
        n_probes   = 0;
        n_repeat   = 0;
        n_update   = 0;
        n_insert   = 0;
        foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    endfunction

    // predict the verdict of one accepted probe and update the table
    function void note_probe(input bit [psdc_pkg::MAC_W-1:0] src,
                             input bit [psdc_pkg::LEN_W-1:0] len_raw,
                             input bit [psdc_pkg::SSID_W-1:0] ssid);
        bit [psdc_pkg::LEN_W-1:0]  len;
        bit [psdc_pkg::SSID_W-1:0] keep;
        verdict_t                  v;
        int                        hit;
        len  = (len_raw > psdc_pkg::SSID_BYTES) ? psdc_pkg::LEN_W'(psdc_pkg::SSID_BYTES)
                                                : len_raw;
        keep = '0;
        for (int b = 0; b < psdc_pkg::SSID_BYTES; b++) begin
            if (b < len) keep[8*b +: 8] = 8'hFF;
        end
        hit = -1;
        for (int i = 0; i < depth; i++) begin
            if (slot_valid[i] && slot_source[i] == src) begin
                hit = i;
                break;
            end
        end
        v.is_new = 1'b1;
        if (hit >= 0) begin
            v.slot = psdc_pkg::SLOT_W'(hit);
            if (slot_length[hit] == len && (slot_ssid[hit] & keep) == (ssid & keep)) begin
                v.is_new  = 1'b0;
                v.outcome = psdc_pkg::OUT_REPEAT;
                n_repeat++;
            end else begin
                v.outcome         = psdc_pkg::OUT_UPDATE;
                slot_length[hit]  = len;
                slot_ssid[hit]    = ssid;
                n_update++;
            end
        end else begin
            v.slot             = psdc_pkg::SLOT_W'(rotor);
            v.outcome          = psdc_pkg::OUT_INSERT;
            slot_valid[rotor]  = 1'b1;
            slot_source[rotor] = src;
            slot_length[rotor] = len;
            slot_ssid[rotor]   = ssid;
            rotor              = (rotor + 1) % depth;
            n_insert++;
        end
        n_probes++;
        verdicts_due.push_back(v);
    endfunction

    // compare one accepted result against the oldest prediction
    function void check_verdict(input logic [psdc_pkg::M_TDATA_W-1:0] data);
        verdict_t want;
        verdict_t got;
        got = data[0 +: $bits(verdict_t)] ;
        got.is_new  = data[0];
        got.outcome = psdc_pkg::outcome_t'(data[2:1]);
        got.slot    = data[6:3];
        if (verdicts_due.size() == 0) begin
            $error("result with no probe pending: tdata %h", data);
            n_mismatch++;
            return;
        end
        want = verdicts_due.pop_front();
        if (got.is_new !== want.is_new) begin
            $error("is_new: expected %0d, got %0d", want.is_new, got.is_new);
            n_mismatch++;
        end
        if (got.outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
            n_mismatch++;
        end
        if (got.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, got.slot);
            n_mismatch++;
        end
    endfunction

    function int pending();
        return verdicts_due.size();
    endfunction

endclass

module probe_source_ssid_dedup_cache_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import psdc_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int RANDOM_ITEMS = 1625;
    // slowest item: long sender gap + full scan + long result stall
    localparam int QUIET_LIMIT  = 4000;
    localparam int POOL         = 24;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    probe_dedup_scoreboard sb;

    // when low, neither side inserts gaps or stalls
    bit idle_on = 1'b1;
    int ready_hold = 0;
    int quiet_cycles = 0;

    // source pool and the last ssid sent per source, for building repeats
    logic [MAC_W-1:0]  pool_mac [POOL];
    logic [LEN_W-1:0]  pool_len [POOL];
    logic [SSID_W-1:0] pool_ssid[POOL];
    bit                pool_used[POOL];

    probe_source_ssid_dedup_cache_top #(
        .ENTRIES (ENTRIES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #1 aclk = ~aclk;

    // mostly short gaps, some medium, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(0, 3);
        if (r < 90) return $urandom_range(4, 24);
        return $urandom_range(25, 60);
    endfunction

    function automatic logic [SSID_W-1:0] rand_ssid();
        logic [SSID_W-1:0] s;
        for (int k = 0; k < SSID_W / 32; k++) s[32*k +: 32] = $urandom;
        return s;
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // one probe onto the input stream; valid stays high across back-to-back items
    task automatic send_probe(input logic [MAC_W-1:0] src, input logic [LEN_W-1:0] len,
                              input logic [SSID_W-1:0] ssid);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        // zero pad, ssid words 3..0, length, source
        s_tdata  <= {2'b00, ssid, len, src};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_probe(src, len, ssid);
    endtask

    // result side: check each accepted item, then pick the next ready value
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) sb.check_verdict(m_tdata);
        if (ready_hold > 0) begin
            ready_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 99) < 20) ready_hold = pick_gap();
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [MAC_W-1:0]  mac_a;
        logic [SSID_W-1:0] ssid_a;
        logic [SSID_W-1:0] ssid;
        logic [LEN_W-1:0]  len;
        int                p;
        int                r;
        int                b;
        sb = new(ENTRIES);
        foreach (pool_mac[i]) begin
            pool_mac[i]  = rand_mac();
            pool_used[i] = 1'b0;
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, wildcard, saturation, bytes past the length
        send_probe('0, 6'd0, '0);                       // insert into slot 0
        send_probe('0, 6'd0, '1);                       // wildcard repeat, bytes ignored
        send_probe('1, 6'd32, '1);                      // all-ones source, full length
        send_probe('1, 6'd63, '1);                      // length saturates, still a repeat
        ssid = '1;
        ssid[SSID_W-1 -: 8] = 8'h00;
        send_probe('1, 6'd32, ssid);                    // last byte differs: update
        mac_a  = rand_mac();
        ssid_a = rand_ssid();
        send_probe(mac_a, 6'd5, ssid_a);                // insert
        ssid = rand_ssid();
        ssid[0 +: 40] = ssid_a[0 +: 40];
        send_probe(mac_a, 6'd5, ssid);                  // only tail bytes differ: repeat
        send_probe(mac_a, 6'd6, ssid);                  // length differs: update
        ssid[40 +: 8] = ~ssid[40 +: 8];
        send_probe(mac_a, 6'd6, ssid);                  // byte inside length differs
        send_probe('0, 6'd1, '0);                       // update of slot 0
        // fill the table and wrap the replacement pointer over slot 0
        for (int k = 0; k < ENTRIES - 2; k++) begin
            send_probe(rand_mac(), 6'($urandom_range(0, 32)), rand_ssid());
        end
        send_probe('0, 6'd0, '0);                       // evicted source comes back

        // random: mostly repeats, updates and near misses over a small source pool
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // stretches with neither side idling
            idle_on = (n % 400) >= 100;
            p = $urandom_range(0, POOL - 1);
            r = $urandom_range(0, 99);
            if (r < 40 && pool_used[p]) begin
                // exact repeat with noise beyond the length, saturated alias of 32
                ssid = rand_ssid();
                for (b = 0; b < SSID_BYTES; b++) begin
                    if (b < pool_len[p]) ssid[8*b +: 8] = pool_ssid[p][8*b +: 8];
                end
                len = pool_len[p];
                if (len == 6'd32 && $urandom_range(0, 1)) len = 6'($urandom_range(33, 63));
                send_probe(pool_mac[p], len, ssid);
            end else if (r < 55 && pool_used[p]) begin
                // near miss: one byte inside the length flipped, or length off by one
                ssid = pool_ssid[p];
                len  = pool_len[p];
                if (len > 0 && $urandom_range(0, 1)) begin
                    b = $urandom_range(0, len - 1);
                    ssid[8*b +: 8] = ssid[8*b +: 8] ^ 8'($urandom_range(1, 255));
                end else if (len == 0 || (len < 32 && $urandom_range(0, 1))) begin
                    len = len + 1;
                end else begin
                    len = len - 1;
                end
                send_probe(pool_mac[p], len, ssid);
                pool_len[p]  = len;
                pool_ssid[p] = ssid;
            end else if (r < 85) begin
                // fresh ssid for a pool source
                len  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                                   : 6'($urandom_range(0, 32));
                ssid = rand_ssid();
                send_probe(pool_mac[p], len, ssid);
                pool_len[p]  = (len > 32) ? 6'd32 : len;
                pool_ssid[p] = ssid;
                pool_used[p] = 1'b1;
            end else begin
                // noise: unknown source, any length
                send_probe(rand_mac(), 6'($urandom), rand_ssid());
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (ENTRIES + 8) @(posedge aclk);

        $display("%0d probes checked: %0d repeats, %0d in-place updates, %0d inserts",
                 sb.n_probes, sb.n_repeat, sb.n_update, sb.n_insert);
        $display("table of %0d slots, source pool of %0d plus random sources", ENTRIES, POOL);
        if (sb.n_mismatch == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
